>>> src/perlin_noise_3d_octaves_top_macros.svh
// assertion macros for the fractal gradient noise block
// used by perlin_noise_3d_octaves_top; expects clk and rst_n in scope
`ifndef PERLIN_NOISE_3D_OCTAVES_TOP_MACROS_SVH
`define PERLIN_NOISE_3D_OCTAVES_TOP_MACROS_SVH

// checked only while out of reset
`define PN3D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define PN3D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pn3d_pkg.sv
// shared types, constants and the permutation table of the fractal noise block
// no dependencies
package pn3d_pkg;

  localparam int CW        = 24;  // coordinate width
  localparam int OUTW      = 16;  // result width
  localparam int OW        = 18;  // per-octave value width, unsigned q.16
  localparam int AW        = 41;  // amplitude width, q.12 up to 2^40
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 16;
  localparam int OCTW      = 4;
  localparam int CNTW      = 5;
  localparam int PERSW     = 16;
  localparam int PERIODW   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd2;

  localparam logic [OCTW-1:0]    OCT_RST    = 4'd1;
  localparam logic [PERSW-1:0]   PERS_RST   = 16'd2048;
  localparam logic [PERIODW-1:0] PERIOD_RST = 9'd0;

  localparam logic [AW-1:0] AMP_ONE = 41'd4096;
  localparam logic [AW-1:0] AMP_CAP = 41'h100_0000_0000;
  localparam logic [AW-1:0] AMP_RND = 41'd2048;
  localparam logic [OW-1:0] RES_MAX = 18'd65535;

  typedef logic [7:0] perm_t;

  localparam perm_t PERM [256] = '{
    151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,
    140,36,103,30,69,142,8,99,37,240,21,10,23,190,6,148,
    247,120,234,75,0,26,197,62,94,252,219,203,117,35,11,32,
    57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,
    74,165,71,134,139,48,27,166,77,146,158,231,83,111,229,122,
    60,211,133,230,220,105,92,41,55,46,245,40,244,102,143,54,
    65,25,63,161,1,216,80,73,209,76,132,187,208,89,18,169,
    200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,
    52,217,226,250,124,123,5,202,38,147,118,126,255,82,85,212,
    207,206,59,227,47,16,58,17,182,189,28,42,223,183,170,213,
    119,248,152,2,44,154,163,70,221,153,101,155,167,43,172,9,
    129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,
    218,246,97,228,251,34,242,193,238,210,144,12,191,179,162,241,
    81,51,145,235,249,14,239,107,49,192,214,31,181,199,106,157,
    184,84,204,176,115,121,50,45,127,4,150,254,138,236,205,93,
    222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
  };

  function automatic perm_t perm_at(input perm_t idx);
    return PERM[idx];
  endfunction

endpackage

>>> src/pn3d_octave.sv
// one octave lane: lattice wrap, hashing, fade, gradients and trilinear blend
// depends on pn3d_pkg
module pn3d_octave import pn3d_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 8,
  parameter int SHIFT       = 0
) (
  input  logic               clk,
  input  logic               adv,
  input  logic [CW-1:0]      coord [3],
  input  logic [PERIODW-1:0] period,
  output logic [OW-1:0]      octave_o
);

  localparam int F   = FRAC_BITS;
  localparam int V   = F + 5;
  localparam int SCW = CW + MAX_OCTAVES - 1;
  localparam int IWM = SCW - F;
  localparam int MS  = (IWM + 7) / 8;
  localparam int IPW = MS * 8;
  localparam int SR  = (F >= 15) ? F - 15 : 0;
  localparam int SL  = (F < 15) ? 15 - F : 0;
  localparam int OXW = V + SL;

  localparam logic signed [V-1:0]   ONE  = V'(1) << F;
  localparam logic signed [2*V-1:0] HALF = (2*V)'(1) << (F - 1);

  // rounded fixed-point rescale of a product
  function automatic logic signed [V-1:0] rnd(input logic signed [2*V-1:0] p);
    logic signed [2*V-1:0] t;
    t = p + HALF;
    return V'(t >>> F);
  endfunction

  function automatic logic signed [V-1:0] blend(input logic signed [V-1:0] a,
                                                input logic signed [V-1:0] b,
                                                input logic signed [V-1:0] w);
    logic signed [V-1:0]   df;
    logic signed [2*V-1:0] pr;
    df = b - a;
    pr = df * w;
    return a + rnd(pr);
  endfunction

  // edge gradient dot product
  function automatic logic signed [V-1:0] grad(input logic [3:0] h,
                                               input logic signed [V-1:0] x,
                                               input logic signed [V-1:0] y,
                                               input logic signed [V-1:0] z);
    logic signed [V-1:0] u;
    logic signed [V-1:0] v;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      v = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = x;
    end else begin
      v = z;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // scaled coordinate split
  logic [IPW-1:0] ip_in   [3];
  logic [F-1:0]   frac_in [3];

  for (genvar d = 0; d < 3; d++) begin : g_split
    logic [SCW-1:0] sc;
    assign sc         = SCW'(coord[d]) << SHIFT;
    assign ip_in[d]   = IPW'(sc[SCW-1:F]);
    assign frac_in[d] = sc[F-1:0];
  end

  // integer part modulo period, eight bits per stage
  logic [IPW-1:0] ip_r    [3][MS];
  logic [8:0]     rem_r   [3][MS];
  logic [IPW-1:0] ip_src  [3][MS];
  logic [8:0]     rem_src [3][MS];
  logic [8:0]     rem_nxt [3][MS];

  for (genvar d = 0; d < 3; d++) begin : g_mod_d
    for (genvar m = 0; m < MS; m++) begin : g_mod_m
      if (m == 0) begin : g_first
        assign ip_src[d][m]  = ip_in[d];
        assign rem_src[d][m] = 9'd0;
      end else begin : g_next
        assign ip_src[d][m]  = ip_r[d][m-1];
        assign rem_src[d][m] = rem_r[d][m-1];
      end

      always_comb begin : c_rem
        logic [8:0] r;
        logic [9:0] t;
        r = rem_src[d][m];
        for (int j = 0; j < 8; j++) begin
          t = {r, ip_src[d][m][IPW-1-8*m-j]};
          if (period != '0 && t >= 10'(period)) begin
            t = t - 10'(period);
          end
          r = t[8:0];
        end
        rem_nxt[d][m] = r;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          ip_r[d][m]  <= ip_src[d][m];
          rem_r[d][m] <= rem_nxt[d][m];
        end
      end
    end
  end

  // lattice indices, lower and upper corner
  perm_t idx_lo [3];
  perm_t idx_hi [3];

  for (genvar d = 0; d < 3; d++) begin : g_idx
    always_comb begin
      logic [8:0] inc;
      idx_lo[d] = (period == '0) ? ip_r[d][MS-1][7:0] : rem_r[d][MS-1][7:0];
      inc       = {1'b0, idx_lo[d]} + 9'd1;
      if (period != '0 && inc == period) begin
        idx_hi[d] = 8'd0;
      end else begin
        idx_hi[d] = inc[7:0];
      end
    end
  end

  // three table levels of the corner hash
  perm_t      px_r [2];
  perm_t      y1_r [2];
  perm_t      z1_r [2];
  perm_t      pa_r [4];
  perm_t      z2_r [2];
  logic [3:0] hh_r [8];

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r[0] <= perm_at(idx_lo[0]);
      px_r[1] <= perm_at(idx_hi[0]);
      y1_r[0] <= idx_lo[1];
      y1_r[1] <= idx_hi[1];
      z1_r[0] <= idx_lo[2];
      z1_r[1] <= idx_hi[2];
      for (int k = 0; k < 4; k++) begin
        pa_r[k] <= perm_at(perm_t'(px_r[k % 2] + y1_r[k / 2]));
      end
      z2_r <= z1_r;
      for (int k = 0; k < 8; k++) begin
        hh_r[k] <= 4'(perm_at(perm_t'(pa_r[k % 4] + z2_r[k / 4])));
      end
    end
  end

  // quintic fade per axis, then delay lines to the blend stages
  localparam int FD = MS + 3;
  localparam int WD = MS + 4;

  logic [F-1:0]        fd_r   [3][FD];
  logic signed [V-1:0] wd_r   [3][WD];
  logic signed [V-1:0] sq_r   [3];
  logic signed [V-1:0] cube_r [3];
  logic signed [V-1:0] poly_r [3];

  for (genvar d = 0; d < 3; d++) begin : g_fade
    logic signed [V-1:0] fi;
    logic signed [V-1:0] f1;
    assign fi = $signed(V'(frac_in[d]));
    assign f1 = $signed(V'(fd_r[d][0]));

    always_ff @(posedge clk) begin
      if (adv) begin
        fd_r[d][0] <= frac_in[d];
        sq_r[d]    <= rnd(fi * fi);
        cube_r[d]  <= rnd(sq_r[d] * f1);
        poly_r[d]  <= V'(6) * sq_r[d] + V'(10) * ONE - V'(15) * f1;
        wd_r[d][0] <= rnd(cube_r[d] * poly_r[d]);
        for (int i = 1; i < FD; i++) begin
          fd_r[d][i] <= fd_r[d][i-1];
        end
        for (int i = 1; i < WD; i++) begin
          wd_r[d][i] <= wd_r[d][i-1];
        end
      end
    end
  end

  // corner gradients
  logic signed [V-1:0] gr_r [8];
  logic signed [V-1:0] fx, fy, fz;
  assign fx = $signed(V'(fd_r[0][FD-1]));
  assign fy = $signed(V'(fd_r[1][FD-1]));
  assign fz = $signed(V'(fd_r[2][FD-1]));

  for (genvar k = 0; k < 8; k++) begin : g_grad
    logic signed [V-1:0] gx, gy, gz;
    assign gx = (k % 2 == 1) ? fx - ONE : fx;
    assign gy = ((k / 2) % 2 == 1) ? fy - ONE : fy;
    assign gz = (k / 4 == 1) ? fz - ONE : fz;
    always_ff @(posedge clk) begin
      if (adv) begin
        gr_r[k] <= grad(hh_r[k], gx, gy, gz);
      end
    end
  end

  // trilinear blend, one axis per stage
  logic signed [V-1:0] l1_r [4];
  logic signed [V-1:0] l2_r [2];
  logic signed [V-1:0] n_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        l1_r[k] <= blend(gr_r[2*k], gr_r[2*k+1], wd_r[0][MS+1]);
      end
      for (int k = 0; k < 2; k++) begin
        l2_r[k] <= blend(l1_r[2*k], l1_r[2*k+1], wd_r[1][MS+2]);
      end
      n_r <= blend(l2_r[0], l2_r[1], wd_r[2][MS+3]);
    end
  end

  // map to 0..1 in q.16 and clamp below
  logic signed [OXW-1:0] ox;
  logic signed [OXW-1:0] oq;
  assign ox = OXW'(n_r + ONE) <<< SL;

  if (SR > 0) begin : g_round
    assign oq = (ox + (OXW'(1) << (SR - 1))) >>> SR;
  end else begin : g_exact
    assign oq = ox;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      octave_o <= (oq < 0) ? '0 : OW'(oq);
    end
  end

endmodule

>>> src/perlin_noise_3d_octaves_top.sv
// fractal gradient noise: octave lanes, weighted sum and normalising divider
// depends on pn3d_pkg, pn3d_octave and perlin_noise_3d_octaves_top_macros.svh
// throughput: one point per cycle, set by one lane per octave and a one-bit-per-stage divider
// the whole pipeline holds while a finished result waits on out_ready
// reset (rst_n low at a clock edge) clears all valids and loads 1, 2048, 0 into the registers
`include "perlin_noise_3d_octaves_top_macros.svh"

module perlin_noise_3d_octaves_top import pn3d_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CW-1:0]        in_coord_x,
  input  logic [CW-1:0]        in_coord_y,
  input  logic [CW-1:0]        in_coord_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUTW-1:0]      out_noise_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  localparam int SCW  = CW + MAX_OCTAVES - 1;
  localparam int IWM  = SCW - FRAC_BITS;
  localparam int MS   = (IWM + 7) / 8;
  localparam int LL   = MS + 8;
  localparam int CB   = $clog2(MAX_OCTAVES + 1);
  localparam int SW   = AW + CB;
  localparam int TW   = OW + AW + CB;
  localparam int QB   = OW;
  localparam int LAT  = LL + MAX_OCTAVES + 1 + QB + 1;
  localparam int NB   = LAT - 1;
  localparam int DIVB = LL + MAX_OCTAVES;

  // configuration registers
  logic [OCTW-1:0]    oct_r;
  logic [PERSW-1:0]   pers_r;
  logic [PERIODW-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r    <= OCT_RST;
      pers_r   <= PERS_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OCTAVES: oct_r    <= cfg_wdata[OCTW-1:0];
        CFG_PERSIST: pers_r   <= cfg_wdata[PERSW-1:0];
        CFG_PERIOD:  period_r <= cfg_wdata[PERIODW-1:0];
        default: ;
      endcase
    end
  end

  // octave count clamped to 1..MAX_OCTAVES
  logic [CNTW-1:0] cnt_c;
  always_comb begin
    if (oct_r == '0) begin
      cnt_c = CNTW'(1);
    end else if (CNTW'(oct_r) > CNTW'(MAX_OCTAVES)) begin
      cnt_c = CNTW'(MAX_OCTAVES);
    end else begin
      cnt_c = CNTW'(oct_r);
    end
  end

  // pipeline advance and valid chain
  logic          adv;
  logic          out_valid_r;
  logic [NB-1:0] vld_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NB-2:0], in_valid};
      out_valid_r <= vld_r[NB-1];
    end
  end

  // octave lanes
  logic [CW-1:0] coord [3];
  logic [OW-1:0] oct_v [MAX_OCTAVES];

  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    pn3d_octave #(
      .FRAC_BITS   (FRAC_BITS),
      .MAX_OCTAVES (MAX_OCTAVES),
      .SHIFT       (k)
    ) u_octave (
      .clk      (clk),
      .adv      (adv),
      .coord    (coord),
      .period   (period_r),
      .octave_o (oct_v[k])
    );
  end

  // weighted sum, one octave per stage, amplitude carried alongside
  logic [OW-1:0] ao_r  [MAX_OCTAVES][MAX_OCTAVES];
  logic [TW-1:0] tot_r [MAX_OCTAVES];
  logic [SW-1:0] sum_r [MAX_OCTAVES];
  logic [AW-1:0] amp_r [MAX_OCTAVES];

  for (genvar s = 0; s < MAX_OCTAVES; s++) begin : g_acc
    logic [OW-1:0]       o_src [MAX_OCTAVES];
    logic [TW-1:0]       tot_src;
    logic [SW-1:0]       sum_src;
    logic [AW-1:0]       amp_src;
    logic [OW+AW-1:0]    prod;
    logic [AW+PERSW-1:0] ap;
    logic [AW+3:0]       ash;
    logic                en;

    if (s == 0) begin : g_first
      assign o_src   = oct_v;
      assign tot_src = '0;
      assign sum_src = '0;
      assign amp_src = AMP_ONE;
    end else begin : g_next
      assign o_src   = ao_r[s-1];
      assign tot_src = tot_r[s-1];
      assign sum_src = sum_r[s-1];
      assign amp_src = amp_r[s-1];
    end

    assign en   = CNTW'(s) < cnt_c;
    assign prod = (OW+AW)'(o_src[s]) * (OW+AW)'(amp_src);
    assign ap   = (AW+PERSW)'(amp_src) * (AW+PERSW)'(pers_r) + (AW+PERSW)'(AMP_RND);
    assign ash  = ap[AW+PERSW-1:12];

    always_ff @(posedge clk) begin
      if (adv) begin
        ao_r[s]  <= o_src;
        tot_r[s] <= en ? tot_src + TW'(prod) : tot_src;
        sum_r[s] <= en ? sum_src + SW'(amp_src) : sum_src;
        amp_r[s] <= (ash > (AW+4)'(AMP_CAP)) ? AMP_CAP : ash[AW-1:0];
      end
    end
  end

  // rounded division by the amplitude sum, one quotient bit per stage
  logic [TW-1:0] num_r;
  logic [SW-1:0] den_r;
  logic [TW-1:0] rem_r [QB];
  logic [SW-1:0] dv_r  [QB];
  logic [QB-1:0] q_r   [QB];

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= tot_r[MAX_OCTAVES-1] + TW'(sum_r[MAX_OCTAVES-1] >> 1);
      den_r <= sum_r[MAX_OCTAVES-1];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [TW-1:0] r_src;
    logic [SW-1:0] d_src;
    logic [QB-1:0] q_src;
    logic [TW-1:0] dsh;

    if (j == 0) begin : g_first
      assign r_src = num_r;
      assign d_src = den_r;
      assign q_src = '0;
    end else begin : g_next
      assign r_src = rem_r[j-1];
      assign d_src = dv_r[j-1];
      assign q_src = q_r[j-1];
    end

    assign dsh = TW'(d_src) << (QB - 1 - j);

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j] <= d_src;
        if (r_src >= dsh) begin
          rem_r[j] <= r_src - dsh;
          q_r[j]   <= q_src | (QB'(1) << (QB - 1 - j));
        end else begin
          rem_r[j] <= r_src;
          q_r[j]   <= q_src;
        end
      end
    end
  end

  // saturate into the output register
  logic [OUTW-1:0] out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= (q_r[QB-1] > RES_MAX) ? OUTW'(RES_MAX) : q_r[QB-1][OUTW-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_r;

  // checks
  `PN3D_ASSERT(a_cnt_range, (cnt_c != '0 && cnt_c <= CNTW'(MAX_OCTAVES)), "octave count out of range")
  `PN3D_ASSERT(a_div_fits, (vld_r[DIVB] |-> num_r < (TW'(den_r) << QB)), "quotient overflow")
  `PN3D_ASSERT(a_den_nonzero, (vld_r[DIVB] |-> den_r != '0), "zero amplitude sum")
  `PN3D_ASSERT_ALWAYS(a_reset_idle, (!rst_n |=> !out_valid), "result valid after reset")

endmodule

>>> test/tb_top.sv
// testbench for the fractal gradient noise block: directed table then random points
// depends on pn3d_pkg and perlin_noise_3d_octaves_top; self-checking with its own predictor
module tb_top;
  import pn3d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LATENCY   = 38;
  localparam int  N_RANDOM  = 1200;
  localparam int  N_PHASES  = 8;
  localparam longint ONE_Q  = 64'sd65536;
  localparam int  NO_CHECK  = -1;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    int            want;  // NO_CHECK leaves it to the predictor
  } point_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CW-1:0]        in_coord_x = '0;
  logic [CW-1:0]        in_coord_y = '0;
  logic [CW-1:0]        in_coord_z = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUTW-1:0]      out_noise_value;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OCTAVES;
  logic [CFG_DW-1:0]    cfg_wdata = '0;

  // mirror of the block's registers
  logic [OCTW-1:0]    octaves_m = OCT_RST;
  logic [PERSW-1:0]   persist_m = PERS_RST;
  logic [PERIODW-1:0] period_m  = PERIOD_RST;

  logic [OUTW-1:0] noise_due[$];
  int              mismatches = 0;
  int              requests = 0;
  int              results = 0;
  int              pending_want = NO_CHECK;
  int              want_due[$];

  perlin_noise_3d_octaves_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_coord_x, .in_coord_y, .in_coord_z,
    .out_valid, .out_ready, .out_noise_value, .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fade_weight(input longint f);
    longint f2, f3, poly;
    f2   = round_shift(f * f, 16);
    f3   = round_shift(f2 * f, 16);
    poly = 6 * f2 + 10 * ONE_Q - 15 * f;
    return round_shift(f3 * poly, 16);
  endfunction

  function automatic longint mix(input longint a, input longint b, input longint w);
    return a + round_shift((b - a) * w, 16);
  endfunction

  function automatic longint gradient(input int hash, input longint x, input longint y,
                                      input longint z);
    int h;
    longint u, v;
    h = hash & 15;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (((h & 1) != 0) ? -u : u) + (((h & 2) != 0) ? -v : v);
  endfunction

  function automatic int lattice_hash(input int a, input int b, input int c);
    return int'(PERM[(int'(PERM[(int'(PERM[a & 255]) + b) & 255]) + c) & 255]);
  endfunction

  function automatic int wrap_next(input int i);
    int n;
    n = i + 1;
    if (period_m != 0) n = n % int'(period_m);
    return n & 255;
  endfunction

  // one octave, signed q.16 around zero
  function automatic longint octave_value(input longint unsigned cx, input longint unsigned cy,
                                          input longint unsigned cz);
    longint unsigned ip[3];
    longint unsigned c[3];
    int     lo[3], hi[3];
    longint f[3], u, v, w, a, b, c0, c1;
    c = '{cx, cy, cz};
    for (int k = 0; k < 3; k++) begin
      ip[k] = c[k] >> 16;
      if (period_m != 0) ip[k] = ip[k] % period_m;
      lo[k] = int'(ip[k] & 255);
      hi[k] = wrap_next(lo[k]);
      f[k]  = longint'(c[k] & 64'hFFFF);
    end
    u = fade_weight(f[0]);
    v = fade_weight(f[1]);
    w = fade_weight(f[2]);
    a  = mix(gradient(lattice_hash(lo[0], lo[1], lo[2]), f[0], f[1], f[2]),
             gradient(lattice_hash(hi[0], lo[1], lo[2]), f[0] - ONE_Q, f[1], f[2]), u);
    b  = mix(gradient(lattice_hash(lo[0], hi[1], lo[2]), f[0], f[1] - ONE_Q, f[2]),
             gradient(lattice_hash(hi[0], hi[1], lo[2]), f[0] - ONE_Q, f[1] - ONE_Q, f[2]), u);
    c0 = mix(a, b, v);
    a  = mix(gradient(lattice_hash(lo[0], lo[1], hi[2]), f[0], f[1], f[2] - ONE_Q),
             gradient(lattice_hash(hi[0], lo[1], hi[2]), f[0] - ONE_Q, f[1], f[2] - ONE_Q), u);
    b  = mix(gradient(lattice_hash(lo[0], hi[1], hi[2]), f[0], f[1] - ONE_Q, f[2] - ONE_Q),
             gradient(lattice_hash(hi[0], hi[1], hi[2]), f[0] - ONE_Q, f[1] - ONE_Q,
                      f[2] - ONE_Q), u);
    c1 = mix(a, b, v);
    return mix(c0, c1, w);
  endfunction

  function automatic logic [OUTW-1:0] predict_noise(input logic [CW-1:0] x,
                                                    input logic [CW-1:0] y,
                                                    input logic [CW-1:0] z);
    int count;
    longint o;
    longint unsigned amp, total, amp_sum, res;
    count = int'(octaves_m);
    if (count < 1) count = 1;
    if (count > 8) count = 8;
    amp = 4096; total = 0; amp_sum = 0;
    for (int i = 0; i < count; i++) begin
      o = round_shift(octave_value(longint'(x) << i, longint'(y) << i, longint'(z) << i)
                      + ONE_Q, 1);
      if (o < 0) o = 0;
      total   += longint'(o) * amp;
      amp_sum += amp;
      amp = (amp * persist_m + 2048) >> 12;
      if (amp > 64'h100_0000_0000) amp = 64'h100_0000_0000;
    end
    res = (total + amp_sum / 2) / amp_sum;
    if (res > 65535) res = 65535;
    return res[OUTW-1:0];
  endfunction

  // ---------------- request side ----------------
  int burst_left = 0;

  task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic [CW-1:0] z, input int want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (in_valid && gap > 0) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left--;
    pending_want <= want;
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_OCTAVES: octaves_m = data[OCTW-1:0];
      CFG_PERSIST: persist_m = data[PERSW-1:0];
      CFG_PERIOD:  period_m  = data[PERIODW-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0:       return CW'($urandom_range(32'h3_FFFF));          // near the origin
      1:       return {8'($urandom_range(255)), 16'h0};         // lattice points
      2:       return {8'($urandom_range(255)), 16'hFFFF};      // just below a lattice point
      default: return CW'($urandom());
    endcase
  endfunction

  // ---------------- request and result monitors ----------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      noise_due.push_back(predict_noise(in_coord_x, in_coord_y, in_coord_z));
      want_due.push_back(pending_want);
      requests++;
    end
    if (rst_n && out_valid && out_ready) begin
      results++;
      if (noise_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_noise_value);
      end else begin
        logic [OUTW-1:0] exp_noise;
        int want;
        exp_noise = noise_due.pop_front();
        want = want_due.pop_front();
        if (want != NO_CHECK && exp_noise != want[OUTW-1:0]) begin
          mismatches++;
          if (mismatches <= 10) $display("table value %0d, predictor %0d", want, exp_noise);
        end
        if (out_noise_value !== exp_noise) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %0d got %0d", exp_noise, out_noise_value);
        end
      end
    end
  end

  // receiver stalls: stretches of always ready, random, and long holds
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 200 == 0) stall_mode <= $urandom_range(3);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(1);
      2:       out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= (stall_cnt % 40) > 30;
    endcase
  end

  // ---------------- stimulus ----------------
  point_row_t directed[] = '{
    '{24'h000000, 24'h000000, 24'h000000, 32768},
    '{24'h010000, 24'h020000, 24'h030000, 32768},
    '{24'hFF0000, 24'hFF0000, 24'hFF0000, 32768},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, NO_CHECK},
    '{24'h00FFFF, 24'h00FFFF, 24'h00FFFF, NO_CHECK},
    '{24'h008000, 24'h008000, 24'h008000, NO_CHECK},
    '{24'h000001, 24'h000000, 24'h000000, NO_CHECK},
    '{24'hFFFFFF, 24'h000000, 24'h000000, NO_CHECK},
    '{24'h000000, 24'hFFFFFF, 24'h000000, NO_CHECK},
    '{24'h000000, 24'h000000, 24'hFFFFFF, NO_CHECK},
    '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, NO_CHECK},
    '{24'h555555, 24'hAAAAAA, 24'h555555, NO_CHECK},
    '{24'h123456, 24'h789ABC, 24'hDEF012, NO_CHECK},
    '{24'h01C000, 24'h024000, 24'h7F4000, NO_CHECK},
    '{24'h804000, 24'h00C000, 24'h10A000, NO_CHECK}
  };

  // octave count, persistence, period; extremes first
  int phase_cfg[N_PHASES][3] = '{
    '{8, 65535, 256}, '{0, 0, 1}, '{15, 4096, 255}, '{4, 2048, 17},
    '{8, 0, 511}, '{2, 32768, 2}, '{-1, -1, -1}, '{-1, -1, -1}
  };

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed points at the reset settings
    foreach (directed[i]) send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].want);
    drain();

    // random phases, each under its own register settings
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_OCTAVES, CFG_DW'((phase_cfg[p][0] < 0) ? $urandom_range(15)
                                                             : phase_cfg[p][0]));
      write_reg(CFG_PERSIST, CFG_DW'((phase_cfg[p][1] < 0) ? $urandom()
                                                             : phase_cfg[p][1]));
      write_reg(CFG_PERIOD,  CFG_DW'((phase_cfg[p][2] < 0) ? $urandom_range(511)
                                                             : phase_cfg[p][2]));
      for (int i = 0; i < N_RANDOM / N_PHASES; i++)
        send_point(rand_coord(), rand_coord(), rand_coord(), NO_CHECK);
      drain();
    end

    $display("%0d points sent over %0d register settings, %0d results checked",
             requests, N_PHASES + 1, results);
    if (mismatches == 0 && noise_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, noise_due.size());
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3ms;
    $display("timeout with %0d results outstanding", noise_due.size());
    $display("status: fail");
    $finish;
  end

endmodule
